[rtl/six_channel_biquad_lowpass_core_macros.svh]
// Assertion macros for the six-channel biquad low-pass core checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SIX_CHANNEL_BIQUAD_LOWPASS_CORE_MACROS_SVH
`define SIX_CHANNEL_BIQUAD_LOWPASS_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BQLP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bqlp check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define BQLP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bqlp check failed: next-cycle implication");

`endif

[rtl/bqlp_pkg.sv]
// Shared types and constants for the six-channel biquad low-pass core.
// No dependencies; imported by every other file of the block but the macros header.
`timescale 1ns / 1ps
`default_nettype none

package bqlp_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int HIST_FRAC   = 16;
	localparam int HIST_BITS   = SAMPLE_BITS + HIST_FRAC;
	localparam int AXES        = 3;
	localparam int CHANNELS    = 2 * AXES;
	localparam int CH_W        = $clog2(CHANNELS);
	localparam int COEF_BITS   = 32;
	localparam int MUL_W       = 32;
	localparam int ACC_BITS    = 2 * MUL_W;
	localparam int CFG_REGS    = 6;
	localparam int CFG_IDX_W   = 3;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_B0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_A1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_A2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_B0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_A1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_A2 = 3'd5;

	localparam logic signed [COEF_BITS-1:0] COEF_RESET [CFG_REGS] = '{
		32'sd10781978,
		-32'sd838065158,
		32'sd344322160,
		32'sd2975876,
		-32'sd954893636,
		32'sd429927300
	};

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] gyro_x_in;
		logic signed [SAMPLE_BITS-1:0] gyro_y_in;
		logic signed [SAMPLE_BITS-1:0] gyro_z_in;
		logic signed [SAMPLE_BITS-1:0] accel_x_in;
		logic signed [SAMPLE_BITS-1:0] accel_y_in;
		logic signed [SAMPLE_BITS-1:0] accel_z_in;
	} bqlp_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] gyro_x_out;
		logic signed [SAMPLE_BITS-1:0] gyro_y_out;
		logic signed [SAMPLE_BITS-1:0] gyro_z_out;
		logic signed [SAMPLE_BITS-1:0] accel_x_out;
		logic signed [SAMPLE_BITS-1:0] accel_y_out;
		logic signed [SAMPLE_BITS-1:0] accel_z_out;
	} bqlp_out_t;

	// Accumulator commands for the shared multiply-accumulate unit
	typedef struct packed {
		logic load_ff;
		logic sub;
	} bqlp_mac_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FF,
		ST_FB1,
		ST_FB2,
		ST_ACC,
		ST_WB,
		ST_PUB
	} bqlp_state_t;

endpackage

`default_nettype wire

[rtl/bqlp_mac.sv]
// Shared multiply-accumulate unit: one registered 32x32 multiplier, a 64-bit
// accumulator, and the history scaling by arithmetic shift with saturation. Uses bqlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bqlp_mac #(
	parameter int COEF_FRAC_BITS = 29
) (
	input  logic                                  clk,
	input  bqlp_pkg::bqlp_mac_ctl_t               ctl,
	input  logic signed [bqlp_pkg::MUL_W-1:0]     op_a,
	input  logic signed [bqlp_pkg::MUL_W-1:0]     op_b,
	output logic signed [bqlp_pkg::HIST_BITS-1:0] y_sat
);
	import bqlp_pkg::*;

	logic signed [ACC_BITS-1:0] prod_s1;
	logic signed [ACC_BITS-1:0] acc_q;
	logic signed [ACC_BITS-1:0] shifted;
	logic                       ovf_pos;
	logic                       ovf_neg;

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		if (ctl.load_ff) begin
			// feed-forward term carries the extra history fraction bits
			acc_q <= {prod_s1[ACC_BITS-1-HIST_FRAC:0], {HIST_FRAC{1'b0}}};
		end else if (ctl.sub) begin
			acc_q <= acc_q - prod_s1;
		end
	end

	always_comb begin
		shifted = acc_q >>> COEF_FRAC_BITS;
		ovf_pos = !shifted[ACC_BITS-1] && (|shifted[ACC_BITS-2:HIST_BITS-1]);
		ovf_neg = shifted[ACC_BITS-1] && !(&shifted[ACC_BITS-2:HIST_BITS-1]);
		if (ovf_pos) begin
			y_sat = {1'b0, {(HIST_BITS-1){1'b1}}};
		end else if (ovf_neg) begin
			y_sat = {1'b1, {(HIST_BITS-1){1'b0}}};
		end else begin
			y_sat = shifted[HIST_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

[rtl/six_channel_biquad_lowpass_core.sv]
// Six-channel biquad low-pass core: top level with sequencer, histories and
// coefficient registers. Uses bqlp_pkg and bqlp_mac.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one set of three gyro and
//   three accelerometer samples. Output channel (out_valid/out_ready/out_data)
//   returns one set of six filtered samples per input transaction.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
//   six coefficient registers; cfg_ready is always high, indexes above 5 are
//   dropped. Write coefficients only while the core is idle.
//   Sequence: one filter pass steps through FF, FB1, FB2, ACC and WB on the
//   shared multiply-accumulate unit (three products, accumulate, write back)
//   and is run for each of the six channels in turn, between the accept state
//   IDLE and the publish state PUB. The first transaction after reset runs
//   PREFILL_COUNT + 1 passes per channel. in_ready is high only while idle, so
//   a new set is taken only after the previous one has left PUB.
//   Reset clears histories, the seeded flag and the handshakes and reloads
//   the default coefficients. A stalled receiver holds out_data in the output
//   register; the next transaction is accepted and filtered meanwhile, and
//   its result waits until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module six_channel_biquad_lowpass_core #(
	parameter int PREFILL_COUNT  = 10,
	parameter int COEF_FRAC_BITS = 29
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  bqlp_pkg::bqlp_in_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output bqlp_pkg::bqlp_out_t                   out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bqlp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bqlp_pkg::COEF_BITS-1:0]        cfg_data
);
	import bqlp_pkg::*;

	localparam int REP_W = $clog2(PREFILL_COUNT + 2);
	localparam logic [REP_W-1:0] REP_LAST = REP_W'(PREFILL_COUNT);
	localparam logic [CH_W-1:0]  CH_LAST  = CH_W'(CHANNELS - 1);
	localparam logic [CH_W-1:0]  CH_ACCEL = CH_W'(AXES);

	bqlp_state_t state_q, state_d;

	logic [CH_W-1:0]                ch_q;
	logic [REP_W-1:0]               rep_q;
	logic                           seeded_q;
	bqlp_in_t                       in_q;
	logic signed [COEF_BITS-1:0]    coef_q [CFG_REGS];
	logic signed [SAMPLE_BITS-1:0]  x1_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0]  x2_q [CHANNELS];
	logic signed [HIST_BITS-1:0]    y1_q [CHANNELS];
	logic signed [HIST_BITS-1:0]    y2_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0]  res_q [CHANNELS];
	bqlp_out_t                      out_q;
	logic                           out_valid_q;

	logic signed [SAMPLE_BITS-1:0]  samp [CHANNELS];
	logic signed [SAMPLE_BITS-1:0]  x_cur;
	logic signed [SAMPLE_BITS+1:0]  ff_sum;
	logic                           is_accel;
	logic signed [COEF_BITS-1:0]    b0_sel;
	logic signed [COEF_BITS-1:0]    a1_sel;
	logic signed [COEF_BITS-1:0]    a2_sel;
	logic                           pass_done;
	logic                           pub_free;
	bqlp_mac_ctl_t                  mac_ctl;
	logic signed [MUL_W-1:0]        op_a;
	logic signed [MUL_W-1:0]        op_b;
	logic signed [HIST_BITS-1:0]    y_sat;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		samp[0] = in_q.gyro_x_in;
		samp[1] = in_q.gyro_y_in;
		samp[2] = in_q.gyro_z_in;
		samp[3] = in_q.accel_x_in;
		samp[4] = in_q.accel_y_in;
		samp[5] = in_q.accel_z_in;
		x_cur    = samp[ch_q];
		ff_sum   = (SAMPLE_BITS+2)'(x_cur) + ((SAMPLE_BITS+2)'(x1_q[ch_q]) <<< 1)
			+ (SAMPLE_BITS+2)'(x2_q[ch_q]);
		is_accel = (ch_q >= CH_ACCEL);
		b0_sel   = is_accel ? coef_q[CFG_ACCEL_B0] : coef_q[CFG_GYRO_B0];
		a1_sel   = is_accel ? coef_q[CFG_ACCEL_A1] : coef_q[CFG_GYRO_A1];
		a2_sel   = is_accel ? coef_q[CFG_ACCEL_A2] : coef_q[CFG_GYRO_A2];
		// unseeded: prefill passes plus the output pass
		pass_done = (rep_q == (seeded_q ? '0 : REP_LAST));
		pub_free  = !out_valid_q || out_ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_FF;
			end
			ST_FF:  state_d = ST_FB1;
			ST_FB1: state_d = ST_FB2;
			ST_FB2: state_d = ST_ACC;
			ST_ACC: state_d = ST_WB;
			ST_WB: begin
				if (pass_done && (ch_q == CH_LAST)) state_d = ST_PUB;
				else state_d = ST_FF;
			end
			ST_PUB: begin
				if (pub_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		mac_ctl  = '0;
		op_a     = b0_sel;
		op_b     = MUL_W'(ff_sum);
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_FF: begin
				op_a = b0_sel;
				op_b = MUL_W'(ff_sum);
			end
			ST_FB1: begin
				mac_ctl.load_ff = 1'b1;
				op_a = a1_sel;
				op_b = MUL_W'(y1_q[ch_q]);
			end
			ST_FB2: begin
				mac_ctl.sub = 1'b1;
				op_a = a2_sel;
				op_b = MUL_W'(y2_q[ch_q]);
			end
			ST_ACC: mac_ctl.sub = 1'b1;
			default: ;
		endcase
	end

	bqlp_mac #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.op_a (op_a),
		.op_b (op_b),
		.y_sat(y_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			rep_q       <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CFG_REGS; i++) coef_q[i] <= COEF_RESET[i];
			for (int i = 0; i < CHANNELS; i++) begin
				x1_q[i] <= '0;
				x2_q[i] <= '0;
				y1_q[i] <= '0;
				y2_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_GYRO_B0, CFG_GYRO_A1, CFG_GYRO_A2,
					CFG_ACCEL_B0, CFG_ACCEL_A1, CFG_ACCEL_A2:
						coef_q[cfg_index] <= cfg_data;
					default: ;
				endcase
			end
			if ((state_q == ST_IDLE) && in_valid) begin
				ch_q  <= '0;
				rep_q <= '0;
			end
			if (state_q == ST_WB) begin
				x2_q[ch_q] <= x1_q[ch_q];
				x1_q[ch_q] <= x_cur;
				y2_q[ch_q] <= y1_q[ch_q];
				y1_q[ch_q] <= y_sat;
				if (pass_done) begin
					rep_q <= '0;
					if (ch_q == CH_LAST) seeded_q <= 1'b1;
					else ch_q <= ch_q + 1'b1;
				end else begin
					rep_q <= rep_q + 1'b1;
				end
			end
			if ((state_q == ST_PUB) && pub_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			in_q <= in_data;
		end
		if ((state_q == ST_WB) && pass_done) begin
			res_q[ch_q] <= y_sat[HIST_BITS-1:HIST_FRAC];
		end
		if ((state_q == ST_PUB) && pub_free) begin
			out_q.gyro_x_out  <= res_q[0];
			out_q.gyro_y_out  <= res_q[1];
			out_q.gyro_z_out  <= res_q[2];
			out_q.accel_x_out <= res_q[3];
			out_q.accel_y_out <= res_q[4];
			out_q.accel_z_out <= res_q[5];
		end
	end

endmodule

`default_nettype wire

[rtl/bqlp_checker.sv]
// Port-level checker for the six-channel biquad low-pass core, bound to the
// top level. Uses bqlp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "six_channel_biquad_lowpass_core_macros.svh"

module bqlp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input bqlp_pkg::bqlp_out_t  out_data,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);
	import bqlp_pkg::*;

	// hold a stalled result
	`BQLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	// go busy right after an input transaction
	`BQLP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// a new result is published only from the busy sequencer
	`BQLP_ASSERT_IMPL(a_pub_from_busy, $rose(out_valid), $past(!in_ready))
	// configuration writes never stall
	`BQLP_ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind six_channel_biquad_lowpass_core bqlp_checker u_bqlp_checker (.*);

`default_nettype wire

[tb/tb_six_channel_biquad_lowpass_core.sv]
// Self-checking bench for six_channel_biquad_lowpass_core: a bit-exact biquad predictor
// in SystemVerilog, random handshake stalls and coefficient phases.
// Depends on bqlp_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_six_channel_biquad_lowpass_core;
	import bqlp_pkg::*;

	localparam int PREFILL_COUNT  = 10;
	localparam int COEF_FRAC_BITS = 29;
	localparam int STALL_LIMIT    = 4000;
	localparam int PHASE_SETS     = 100;
	localparam int IDLE_PCT       = 16;

	// Indexes past the register file; the core must drop these writes
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_ORDER [CFG_REGS] = '{
		CFG_GYRO_B0, CFG_GYRO_A1, CFG_GYRO_A2, CFG_ACCEL_B0, CFG_ACCEL_A1, CFG_ACCEL_A2
	};

	localparam logic signed [63:0] HIST_MAX = (64'sd1 <<< (HIST_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] HIST_MIN = -HIST_MAX - 64'sd1;

	typedef enum {COEF_DEFAULT, COEF_TYPICAL, COEF_RANDOM, COEF_EXTREME} coef_mix_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	bqlp_in_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	bqlp_out_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [COEF_BITS-1:0]  cfg_data;

	// Predictor state: coefficient banks (0 gyro, 1 accel) and per-channel histories
	logic signed [COEF_BITS-1:0]   b0_bank [2] = '{COEF_RESET[CFG_GYRO_B0], COEF_RESET[CFG_ACCEL_B0]};
	logic signed [COEF_BITS-1:0]   a1_bank [2] = '{COEF_RESET[CFG_GYRO_A1], COEF_RESET[CFG_ACCEL_A1]};
	logic signed [COEF_BITS-1:0]   a2_bank [2] = '{COEF_RESET[CFG_GYRO_A2], COEF_RESET[CFG_ACCEL_A2]};
	logic signed [SAMPLE_BITS-1:0] x_hist [CHANNELS][2] = '{default: '0};
	logic signed [HIST_BITS-1:0]   y_hist [CHANNELS][2] = '{default: '0};
	bit                            history_primed = 1'b0;

	bqlp_out_t pending_filtered [$];
	bqlp_out_t oldest_set;
	int        mismatches = 0;
	int        stall_cycles = 0;
	bit        no_idle = 1'b0;

	six_channel_biquad_lowpass_core #(
		.PREFILL_COUNT (PREFILL_COUNT),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One direct-form-I pass of channel ch; advances that channel's histories
	function automatic logic signed [HIST_BITS-1:0] run_biquad_pass(int ch,
			logic signed [SAMPLE_BITS-1:0] x);
		logic signed [63:0] b0, a1, a2, y1, y2, tap_sum, acc;
		int bank;
		bank = (ch < AXES) ? 0 : 1;
		b0 = 64'(b0_bank[bank]);
		a1 = 64'(a1_bank[bank]);
		a2 = 64'(a2_bank[bank]);
		y1 = 64'(y_hist[ch][0]);
		y2 = 64'(y_hist[ch][1]);
		tap_sum = 64'(x) + 64'sd2 * 64'(x_hist[ch][0]) + 64'(x_hist[ch][1]);
		acc = ((b0 * tap_sum) <<< HIST_FRAC) - (a1 * y1 + a2 * y2);
		acc = acc >>> COEF_FRAC_BITS;
		if (acc > HIST_MAX)
			acc = HIST_MAX;
		else if (acc < HIST_MIN)
			acc = HIST_MIN;
		x_hist[ch][1] = x_hist[ch][0];
		x_hist[ch][0] = x;
		y_hist[ch][1] = y_hist[ch][0];
		y_hist[ch][0] = acc[HIST_BITS-1:0];
		return acc[HIST_BITS-1:0];
	endfunction

	function automatic bqlp_out_t predict_filtered_set(bqlp_in_t v);
		logic signed [SAMPLE_BITS-1:0] x [CHANNELS];
		logic signed [HIST_BITS-1:0]   y [CHANNELS];
		logic signed [HIST_BITS-1:0]   scrap;
		bqlp_out_t r;
		x[0] = v.gyro_x_in;
		x[1] = v.gyro_y_in;
		x[2] = v.gyro_z_in;
		x[3] = v.accel_x_in;
		x[4] = v.accel_y_in;
		x[5] = v.accel_z_in;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			// first set after reset seeds the history with its own sample
			if (!history_primed)
				for (int n = 0; n < PREFILL_COUNT; n++)
					scrap = run_biquad_pass(ch, x[ch]);
			y[ch] = run_biquad_pass(ch, x[ch]) >>> HIST_FRAC;
		end
		history_primed = 1'b1;
		r.gyro_x_out  = y[0][SAMPLE_BITS-1:0];
		r.gyro_y_out  = y[1][SAMPLE_BITS-1:0];
		r.gyro_z_out  = y[2][SAMPLE_BITS-1:0];
		r.accel_x_out = y[3][SAMPLE_BITS-1:0];
		r.accel_y_out = y[4][SAMPLE_BITS-1:0];
		r.accel_z_out = y[5][SAMPLE_BITS-1:0];
		return r;
	endfunction

	function automatic void store_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_BITS-1:0] val);
		case (idx)
			CFG_GYRO_B0:  b0_bank[0] = val;
			CFG_GYRO_A1:  a1_bank[0] = val;
			CFG_GYRO_A2:  a2_bank[0] = val;
			CFG_ACCEL_B0: b0_bank[1] = val;
			CFG_ACCEL_A1: a1_bank[1] = val;
			CFG_ACCEL_A2: a2_bank[1] = val;
			default: ;
		endcase
	endfunction

	function automatic logic [COEF_BITS-1:0] extreme_coef();
		case ($urandom_range(4))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return 32'h0000_0001;
		endcase
	endfunction

	function automatic logic [COEF_BITS-1:0] pick_coef(coef_mix_t mix, logic [CFG_IDX_W-1:0] idx);
		case (mix)
			COEF_DEFAULT: return COEF_RESET[idx];
			COEF_TYPICAL: begin
				// low-pass-like: small b0, a1 in [-2, -0.5], a2 in [0, 0.875]
				if (idx == CFG_GYRO_B0 || idx == CFG_ACCEL_B0)
					return $urandom_range(32'h0100_0000);
				if (idx == CFG_GYRO_A1 || idx == CFG_ACCEL_A1)
					return -$urandom_range(32'h4000_0000, 32'h1000_0000);
				return $urandom_range(32'h1C00_0000);
			end
			COEF_RANDOM: return $urandom;
			default: return extreme_coef();
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return SAMPLE_BITS'($urandom);
			5, 6, 7: return SAMPLE_BITS'($urandom_range(512) - 256);
			default: begin
				case ($urandom_range(4))
					0: return 16'h7FFF;
					1: return 16'h8000;
					2: return 16'h0000;
					3: return 16'hFFFF;
					default: return 16'h0001;
				endcase
			end
		endcase
	endfunction

	function automatic bqlp_in_t make_set(logic [SAMPLE_BITS-1:0] gx, logic [SAMPLE_BITS-1:0] gy,
			logic [SAMPLE_BITS-1:0] gz, logic [SAMPLE_BITS-1:0] ax, logic [SAMPLE_BITS-1:0] ay,
			logic [SAMPLE_BITS-1:0] az);
		bqlp_in_t v;
		v.gyro_x_in  = gx;
		v.gyro_y_in  = gy;
		v.gyro_z_in  = gz;
		v.accel_x_in = ax;
		v.accel_y_in = ay;
		v.accel_z_in = az;
		return v;
	endfunction

	// Hold valid and data until accepted; queue the prediction on acceptance
	task automatic send_set(bqlp_in_t v);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= v;
		do @(posedge clk); while (!in_ready);
		pending_filtered.push_back(predict_filtered_set(v));
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_filtered.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		store_coef(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_coef_mix(coef_mix_t mix);
		drain_results();
		foreach (REG_ORDER[i])
			write_coef(REG_ORDER[i], pick_coef(mix, REG_ORDER[i]));
	endtask

	task automatic test_startup_prefill();
		send_set(make_set(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555));
	endtask

	task automatic test_sample_extremes();
		repeat (3) send_set(make_set(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		repeat (3) send_set(make_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send_set(make_set(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_set(make_set(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
		send_set(make_set(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
		send_set(make_set(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
	endtask

	task automatic test_coef_extremes();
		// drive the history into saturation
		drain_results();
		write_coef(CFG_GYRO_B0,  32'h7FFF_FFFF);
		write_coef(CFG_GYRO_A1,  32'h0000_0000);
		write_coef(CFG_GYRO_A2,  32'h0000_0000);
		write_coef(CFG_ACCEL_B0, 32'h8000_0000);
		write_coef(CFG_ACCEL_A1, 32'h7FFF_FFFF);
		write_coef(CFG_ACCEL_A2, 32'h8000_0000);
		send_set(make_set(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
		send_set(make_set(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
		send_set(make_set(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		// full-scale feedback on a saturated history wraps the accumulator
		drain_results();
		write_coef(CFG_GYRO_A1,  32'h8000_0000);
		write_coef(CFG_GYRO_A2,  32'h7FFF_FFFF);
		write_coef(CFG_ACCEL_B0, 32'h0000_0001);
		write_coef(CFG_ACCEL_A1, 32'hFFFF_FFFF);
		write_coef(CFG_ACCEL_A2, 32'h0000_0000);
		write_coef(CFG_SPARE_LO, 32'hFFFF_FFFF);
		write_coef(CFG_SPARE_HI, 32'h5555_AAAA);
		send_set(make_set(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF));
		send_set(make_set(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000));
		send_set(make_set(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
	endtask

	task automatic test_random_phases();
		coef_mix_t mixes [7] = '{COEF_DEFAULT, COEF_TYPICAL, COEF_RANDOM, COEF_EXTREME,
			COEF_TYPICAL, COEF_RANDOM, COEF_DEFAULT};
		int pause_at;
		foreach (mixes[p]) begin
			apply_coef_mix(mixes[p]);
			no_idle = (p == 4);
			pause_at = $urandom_range(20, 80);
			for (int n = 0; n < PHASE_SETS; n++) begin
				if (n == pause_at)
					drain_results();
				send_set(make_set(random_sample(), random_sample(), random_sample(),
					random_sample(), random_sample(), random_sample()));
			end
			no_idle = 1'b0;
		end
	endtask

	function automatic void check_channel(string name, logic [SAMPLE_BITS-1:0] want,
			logic [SAMPLE_BITS-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
			mismatches++;
		end
	endfunction

	always @(negedge clk)
		out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_filtered.size() == 0) begin
				$error("output transaction with no pending expectation: %h", out_data);
				mismatches++;
			end else begin
				oldest_set = pending_filtered.pop_front();
				check_channel("gyro_x_out",  oldest_set.gyro_x_out,  out_data.gyro_x_out);
				check_channel("gyro_y_out",  oldest_set.gyro_y_out,  out_data.gyro_y_out);
				check_channel("gyro_z_out",  oldest_set.gyro_z_out,  out_data.gyro_z_out);
				check_channel("accel_x_out", oldest_set.accel_x_out, out_data.accel_x_out);
				check_channel("accel_y_out", oldest_set.accel_y_out, out_data.accel_y_out);
				check_channel("accel_z_out", oldest_set.accel_z_out, out_data.accel_z_out);
			end
		end
	end

	// Watchdog: abort when no transaction completes on any channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_startup_prefill();
		test_sample_extremes();
		test_coef_extremes();
		test_random_phases();

		drain_results();
		repeat (48) @(posedge clk);
		if (pending_filtered.size() != 0) begin
			$error("%0d expected results never arrived", pending_filtered.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
